// ===== hw/rtl/goci_pkg.sv =====
// Package for the grid obstacle cost inflation block.
// Holds the payload structs, the sequencer state type and the Q1.16 exp tables.
// No dependencies.
package goci_pkg;

    typedef struct packed {
        logic        req_type;
        logic [11:0] cell_index;
        logic        occupied;
    } t_req;

    typedef struct packed {
        logic [6:0] occupancy;
        logic [7:0] cell_cost;
        logic       no_obstacle;
    } t_rsp;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [2:0] CFG_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_INS_DIST = 3'd2;
    localparam logic [2:0] CFG_DECAY    = 3'd3;
    localparam logic [2:0] CFG_OCC_TH   = 3'd4;
    localparam logic [2:0] CFG_FREE_TH  = 3'd5;
    localparam logic [2:0] CFG_INS_COST = 3'd6;
    localparam logic [2:0] CFG_LETHAL   = 3'd7;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QDIV,
        ST_OWN,
        ST_SCAN,
        ST_INS,
        ST_SQRT,
        ST_XMUL,
        ST_EXP1,
        ST_EXP2,
        ST_COST,
        ST_MAP,
        ST_DIV,
        ST_OUT
    } t_state;

    // exp(-k) for integer k, Q1.16
    function automatic logic [16:0] exp_int(input logic [2:0] k);
        logic [16:0] v;
        unique case (k)
            3'd0: v = 17'd65536;
            3'd1: v = 17'd24109;
            3'd2: v = 17'd8869;
            3'd3: v = 17'd3263;
            3'd4: v = 17'd1200;
            3'd5: v = 17'd442;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // exp(-k/16), Q1.16
    function automatic logic [16:0] exp_hi(input logic [3:0] k);
        logic [16:0] v;
        unique case (k)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd61565;
            4'd2:  v = 17'd57835;
            4'd3:  v = 17'd54331;
            4'd4:  v = 17'd51039;
            4'd5:  v = 17'd47947;
            4'd6:  v = 17'd45042;
            4'd7:  v = 17'd42313;
            4'd8:  v = 17'd39750;
            4'd9:  v = 17'd37341;
            4'd10: v = 17'd35079;
            4'd11: v = 17'd32954;
            4'd12: v = 17'd30957;
            4'd13: v = 17'd29081;
            4'd14: v = 17'd27319;
            4'd15: v = 17'd25664;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // exp(-k/256), Q1.16
    function automatic logic [16:0] exp_lo(input logic [3:0] k);
        logic [16:0] v;
        unique case (k)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd65280;
            4'd2:  v = 17'd65026;
            4'd3:  v = 17'd64772;
            4'd4:  v = 17'd64520;
            4'd5:  v = 17'd64268;
            4'd6:  v = 17'd64018;
            4'd7:  v = 17'd63768;
            4'd8:  v = 17'd63520;
            4'd9:  v = 17'd63272;
            4'd10: v = 17'd63025;
            4'd11: v = 17'd62780;
            4'd12: v = 17'd62535;
            4'd13: v = 17'd62291;
            4'd14: v = 17'd62048;
            4'd15: v = 17'd61806;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/grid_obstacle_cost_inflation.sv =====
// Top level of the grid obstacle cost inflation block.
// Depends on goci_pkg (payload structs, state type, exp tables).
//
// After reset the block clears its obstacle grid, one cell a cycle, until all
// MAX_CELLS cells are clear; configuration writes are taken meanwhile, items are
// not. A load gives no result. A query first runs a 12-step index divide, then
// reads the grid memory once per scanned cell, n = min(width*height, MAX_CELLS),
// to find the nearest obstacle; a small sequencer then runs a bit-pair square
// root, two table multiplies and a 7-step divide on one shared set of registers.
// The block takes one item at a time; a finished result waits in an output
// register while the next item is taken.
module grid_obstacle_cost_inflation #(
    parameter int MAX_CELLS = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  goci_pkg::t_req     i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output goci_pkg::t_rsp     o_data,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    import goci_pkg::*;

    localparam int AW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CW   = $clog2(MAX_CELLS + 1);
    localparam int YW   = ((AW > 12) ? AW : 12) + 1;
    localparam int D2W  = 2 * YW;
    localparam int SW   = D2W + 16;
    localparam int RW   = SW / 2;
    localparam int XW   = RW + 8;

    // configuration
    logic [6:0]  r_width, r_height;
    logic [15:0] r_ins_dist, r_decay, r_occ_th, r_free_th;
    logic [7:0]  r_ins_cost, r_lethal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= 7'd64;
            r_height   <= 7'd64;
            r_ins_dist <= 16'd512;
            r_decay    <= 16'd256;
            r_occ_th   <= 16'd42598;
            r_free_th  <= 16'd12845;
            r_ins_cost <= 8'd253;
            r_lethal   <= 8'd254;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:    r_width    <= i_cfg_data[6:0];
                CFG_HEIGHT:   r_height   <= i_cfg_data[6:0];
                CFG_INS_DIST: r_ins_dist <= i_cfg_data;
                CFG_DECAY:    r_decay    <= i_cfg_data;
                CFG_OCC_TH:   r_occ_th   <= i_cfg_data;
                CFG_FREE_TH:  r_free_th  <= i_cfg_data;
                CFG_INS_COST: r_ins_cost <= i_cfg_data[7:0];
                CFG_LETHAL:   r_lethal   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic [6:0] w_eff, h_eff;
    assign w_eff = (r_width == 7'd0) ? 7'd1 : r_width;
    assign h_eff = (r_height == 7'd0) ? 7'd1 : r_height;

    // sequencer state
    t_state r_state, n_state;

    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  r_n;
    logic [5:0]     r_k;
    logic [11:0]    r_idx;
    logic           r_idx_in;
    logic [6:0]     r_qr;
    logic [11:0]    r_qy;
    logic [6:0]     r_sx;
    logic [AW-1:0]  r_sy;
    logic           r_pv;
    logic [6:0]     r_px;
    logic [AW-1:0]  r_py;
    logic           r_found;
    logic [D2W-1:0] r_best;
    logic [SW-1:0]  r_sv;
    logic [RW+1:0]  r_rem;
    logic [RW-1:0]  r_root;
    logic [XW-1:0]  r_xq;
    logic [16:0]    r_e;
    logic           r_ezero;
    logic [7:0]     r_cost;
    logic [30:0]    r_num;
    logic [29:0]    r_dsh;
    logic [6:0]     r_q;
    t_rsp           r_res;
    logic           r_o_valid;
    t_rsp           r_o_data;

    // grid memory
    logic           mem [MAX_CELLS];
    logic           r_mem_q;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic           mem_wdata;
    logic [AW-1:0]  mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= mem[mem_raddr];
    end

    // combinational helpers
    logic           accept;
    logic           in_range;
    logic           issuing;
    logic           scan_done;
    logic [7:0]     div_rem;
    logic           div_ge;
    logic [13:0]    wh;
    logic signed [7:0]    dx;
    logic signed [YW-1:0] dy;
    logic [YW-1:0]  adx, ady;
    logic [D2W-1:0] d2;
    logic           ins_hit;
    logic [RW+1:0]  sq_rem;
    logic [RW+1:0]  sq_trial;
    logic           sq_ge;
    logic [RW-1:0]  diff;
    logic [RW+15:0] xprod;
    logic [33:0]    e1prod;
    logic [33:0]    e2prod;
    logic [7:0]     scale;
    logic [24:0]    cprod;
    logic [23:0]    v_cost, hi_th, lo_th;
    logic [30:0]    num_full;
    logic           out_free;

    assign accept    = i_valid && o_ready;
    assign in_range  = (32'(i_data.cell_index) < MAX_CELLS);
    assign issuing   = (r_cnt < r_n);
    assign scan_done = !issuing && !r_pv;
    assign wh        = w_eff * h_eff;
    assign out_free  = !r_o_valid || i_ready;

    assign div_rem = {r_qr, r_idx[r_k[3:0]]};
    assign div_ge  = (div_rem >= {1'b0, w_eff});

    // square the magnitudes at full width
    assign dx  = $signed({1'b0, r_px}) - $signed({1'b0, r_qr});
    assign dy  = $signed(YW'(r_py)) - $signed(YW'(r_qy));
    assign adx = dx[7] ? YW'(-dx) : YW'(dx);
    assign ady = dy[YW-1] ? YW'(-dy) : YW'(dy);
    assign d2  = D2W'(adx) * D2W'(adx) + D2W'(ady) * D2W'(ady);

    assign ins_hit = ({r_best, 16'd0} <= SW'(32'(r_ins_dist) * 32'(r_ins_dist)));

    assign sq_rem   = {r_rem[RW-1:0], r_sv[SW-1 -: 2]};
    assign sq_trial = {r_root, 2'b01};
    assign sq_ge    = (sq_rem >= sq_trial);

    assign diff   = (r_root > RW'(r_ins_dist)) ? (r_root - RW'(r_ins_dist)) : '0;
    assign xprod  = r_decay * diff;
    assign e1prod = exp_int(r_xq[10:8]) * exp_hi(r_xq[7:4]);
    assign e2prod = r_e * exp_lo(r_xq[3:0]);
    assign scale  = (r_ins_cost != 8'd0) ? (r_ins_cost - 8'd1) : 8'd0;
    assign cprod  = scale * r_e;

    assign v_cost   = {r_cost, 16'd0};
    assign hi_th    = {r_occ_th, 8'd0} - 24'(r_occ_th);
    assign lo_th    = {r_free_th, 8'd0} - 24'(r_free_th);
    assign num_full = (v_cost - lo_th) * 7'd99;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_cnt == CW'(MAX_CELLS - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (accept && i_data.req_type == REQ_QUERY) n_state = ST_QDIV;
            ST_QDIV:  if (r_k == 6'd0) n_state = ST_OWN;
            ST_OWN:   n_state = (r_idx_in && r_mem_q) ? ST_MAP : ST_SCAN;
            ST_SCAN: begin
                if (scan_done) n_state = r_found ? ST_INS : ST_OUT;
            end
            ST_INS:   n_state = ins_hit ? ST_MAP : ST_SQRT;
            ST_SQRT:  if (r_k == 6'd0) n_state = ST_XMUL;
            ST_XMUL:  n_state = ST_EXP1;
            ST_EXP1:  n_state = ST_EXP2;
            ST_EXP2:  n_state = ST_COST;
            ST_COST:  n_state = ST_MAP;
            ST_MAP: begin
                if (v_cost > hi_th || v_cost < lo_th || hi_th <= lo_th) n_state = ST_OUT;
                else n_state = ST_DIV;
            end
            ST_DIV:   if (r_k == 6'd0) n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = AW'(i_data.cell_index);
        mem_wdata = i_data.occupied;
        mem_raddr = AW'(r_idx);
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt[AW-1:0];
                mem_wdata = 1'b0;
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                mem_we  = i_valid && i_data.req_type == REQ_LOAD && in_range;
            end
            ST_SCAN: mem_raddr = r_cnt[AW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (r_state == ST_OWN) begin
                r_cnt <= '0;
            end else if (r_state == ST_SCAN && issuing) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_idx    <= i_data.cell_index;
                r_idx_in <= in_range;
                r_k      <= 6'd11;
                r_qr     <= '0;
                r_qy     <= '0;
                r_n      <= (32'(wh) > MAX_CELLS) ? CW'(MAX_CELLS) : CW'(wh);
            end
            ST_QDIV: begin
                // restoring divide of the index by the row width
                r_qr <= div_ge ? 7'(div_rem - {1'b0, w_eff}) : div_rem[6:0];
                r_qy <= {r_qy[10:0], div_ge};
                r_k  <= r_k - 6'd1;
            end
            ST_OWN: begin
                r_cost  <= r_lethal;
                r_sx    <= '0;
                r_sy    <= '0;
                r_pv    <= 1'b0;
                r_found <= 1'b0;
                r_best  <= '0;
            end
            ST_SCAN: begin
                r_pv <= issuing;
                r_px <= r_sx;
                r_py <= r_sy;
                if (issuing) begin
                    if (r_sx == w_eff - 7'd1) begin
                        r_sx <= '0;
                        r_sy <= r_sy + AW'(1);
                    end else begin
                        r_sx <= r_sx + 7'd1;
                    end
                end
                if (r_pv && r_mem_q && (!r_found || d2 < r_best)) begin
                    r_best  <= d2;
                    r_found <= 1'b1;
                end
                r_res <= '{occupancy: 7'd0, cell_cost: 8'd0, no_obstacle: 1'b1};
            end
            ST_INS: begin
                r_cost <= r_ins_cost;
                r_sv   <= {r_best, 16'd0};
                r_rem  <= '0;
                r_root <= '0;
                r_k    <= 6'(RW - 1);
            end
            ST_SQRT: begin
                // one result bit per step
                r_rem  <= sq_ge ? (sq_rem - sq_trial) : sq_rem;
                r_root <= {r_root[RW-2:0], sq_ge};
                r_sv   <= {r_sv[SW-3:0], 2'b00};
                r_k    <= r_k - 6'd1;
            end
            ST_XMUL: r_xq <= xprod[RW+15:8];
            ST_EXP1: begin
                r_ezero <= (r_xq[XW-1:8] > (XW-8)'(5));
                r_e     <= e1prod[32:16];
            end
            ST_EXP2: r_e <= r_ezero ? 17'd0 : e2prod[32:16];
            ST_COST: r_cost <= (cprod[24:16] > 9'd255) ? 8'd255 : cprod[23:16];
            ST_MAP: begin
                r_res.cell_cost   <= r_cost;
                r_res.no_obstacle <= 1'b0;
                priority if (v_cost > hi_th) r_res.occupancy <= 7'd100;
                else r_res.occupancy <= 7'd0;
                r_num <= num_full;
                r_dsh <= {hi_th - lo_th, 6'd0};
                r_q   <= '0;
                r_k   <= 6'd6;
            end
            ST_DIV: begin
                // quotient is below 128: seven compare-subtract steps
                if (r_num >= {1'b0, r_dsh}) begin
                    r_num <= r_num - {1'b0, r_dsh};
                    r_q   <= {r_q[5:0], 1'b1};
                end else begin
                    r_q   <= {r_q[5:0], 1'b0};
                end
                r_dsh <= {1'b0, r_dsh[29:1]};
                r_k   <= r_k - 6'd1;
                if (r_k == 6'd0) begin
                    r_res.occupancy <= (r_num >= {1'b0, r_dsh}) ? {r_q[5:0], 1'b1}
                                                                : {r_q[5:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_o_data <= r_res;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

// ===== dv/grid_obstacle_cost_inflation_tb.sv =====
// Self-checking testbench for grid_obstacle_cost_inflation: directed table, then
// random load/query phases under several register settings and idle patterns.
// Depends on goci_pkg and the block's RTL only.
`timescale 1ns / 100ps

module grid_obstacle_cost_inflation_tb;
    import goci_pkg::*;

    localparam int NUM_CELLS    = 4096;
    localparam int STALL_LIMIT  = 30000;
    localparam int SETTLE_TICKS = 60;

    // exp(-k), exp(-k/16), exp(-k/256) in Q1.16
    localparam logic [16:0] EXP_WHOLE [6] = '{65536, 24109, 8869, 3263, 1200, 442};
    localparam logic [16:0] EXP_SIXTEENTH [16] = '{
        65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
        39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
    localparam logic [16:0] EXP_FINE [16] = '{
        65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
        63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp want;
    } t_dir_row;

    typedef struct {
        logic [6:0]  w, h;
        logic [15:0] ins_dist, decay, occ_th, free_th;
        logic [7:0]  ins_cost, lethal;
        int          items;
    } t_setting;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_req        i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_rsp        o_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = CFG_WIDTH;
    logic [15:0] i_cfg_data = '0;

    grid_obstacle_cost_inflation dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow of the block's grid and registers
    bit          obstacle_map [NUM_CELLS];
    logic [6:0]  m_w, m_h;
    logic [15:0] m_ins_dist, m_decay, m_occ_th, m_free_th;
    logic [7:0]  m_ins_cost, m_lethal;

    t_rsp pending_rsp [$];
    int   send_idle_pct = 32;
    int   recv_idle_pct = 74;
    int   fail_count = 0;
    int   quiet_cycles = 0;

    function automatic logic [63:0] root_q8(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic logic [7:0] decayed_cost(input logic [63:0] d2);
        logic [63:0] ins, dq, diff, x, e, scale, c;
        ins = m_ins_dist;
        if (d2 * 65536 <= ins * ins) return m_ins_cost;
        dq = root_q8(d2 << 16);
        diff = (dq > ins) ? dq - ins : 0;
        x = (m_decay * diff) >> 8;
        e = 0;
        if ((x >> 8) <= 5) begin
            e = (EXP_WHOLE[x >> 8] * EXP_SIXTEENTH[(x >> 4) & 15]) >> 16;
            e = (e * EXP_FINE[x & 15]) >> 16;
        end
        scale = (m_ins_cost > 0) ? m_ins_cost - 1 : 0;
        c = (scale * e) >> 16;
        return (c > 255) ? 8'd255 : c[7:0];
    endfunction

    function automatic logic [6:0] occupancy_of(input logic [7:0] cost);
        logic [63:0] v, hi, lo, q;
        v = cost * 64'd65536;
        hi = m_occ_th * 64'd255;
        lo = m_free_th * 64'd255;
        if (v > hi) return 7'd100;
        if (v < lo) return 7'd0;
        if (hi <= lo) return 7'd0;
        q = ((v - lo) * 99) / (hi - lo);
        return q[6:0];
    endfunction

    function automatic int scanned_cells();
        int w, h, n;
        w = (m_w == 0) ? 1 : m_w;
        h = (m_h == 0) ? 1 : m_h;
        n = w * h;
        return (n > NUM_CELLS) ? NUM_CELLS : n;
    endfunction

    // returns 1 and the result for a query; loads update the shadow grid
    function automatic bit apply_item(input t_req rq, output t_rsp rsp);
        int w, qx, qy, dx, dy;
        logic [63:0] d2, best;
        bit found;
        logic [7:0] cost;
        rsp = '0;
        if (rq.req_type == REQ_LOAD) begin
            obstacle_map[rq.cell_index] = rq.occupied;
            return 0;
        end
        if (obstacle_map[rq.cell_index]) begin
            cost = m_lethal;
        end else begin
            w = (m_w == 0) ? 1 : m_w;
            qx = rq.cell_index % w;
            qy = rq.cell_index / w;
            found = 0;
            best = 0;
            for (int i = 0; i < scanned_cells(); i++) begin
                if (obstacle_map[i]) begin
                    dx = i % w - qx;
                    dy = i / w - qy;
                    d2 = 64'(dx * dx + dy * dy);
                    if (!found || d2 < best) begin
                        best = d2;
                        found = 1;
                    end
                end
            end
            if (!found) begin
                rsp.no_obstacle = 1'b1;
                return 1;
            end
            cost = decayed_cost(best);
        end
        rsp.occupancy = occupancy_of(cost);
        rsp.cell_cost = cost;
        return 1;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_WIDTH:    m_w = val[6:0];
            CFG_HEIGHT:   m_h = val[6:0];
            CFG_INS_DIST: m_ins_dist = val;
            CFG_DECAY:    m_decay = val;
            CFG_OCC_TH:   m_occ_th = val;
            CFG_FREE_TH:  m_free_th = val;
            CFG_INS_COST: m_ins_cost = val[7:0];
            default:      m_lethal = val[7:0];
        endcase
    endtask

    task automatic apply_setting(input t_setting s);
        write_reg(CFG_WIDTH, 16'(s.w));
        write_reg(CFG_HEIGHT, 16'(s.h));
        write_reg(CFG_INS_DIST, s.ins_dist);
        write_reg(CFG_DECAY, s.decay);
        write_reg(CFG_OCC_TH, s.occ_th);
        write_reg(CFG_FREE_TH, s.free_th);
        write_reg(CFG_INS_COST, 16'(s.ins_cost));
        write_reg(CFG_LETHAL, 16'(s.lethal));
        i_cfg_we <= 1'b0;
    endtask

    // always advance the clock before checking the queue
    task automatic drain_results();
        do @(posedge i_clk); while (pending_rsp.size() != 0);
    endtask

    // typed rows push their own result; others use the shadow model
    task automatic transfer_item(input t_req rq, input bit typed, input t_rsp want);
        t_rsp rsp;
        bit   has_rsp;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_data <= rq;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        has_rsp = apply_item(rq, rsp);
        if (has_rsp) pending_rsp.insert(pending_rsp.size(), typed ? want : rsp);
    endtask

    function automatic t_req random_item();
        t_req rq;
        rq.req_type = 1'($urandom_range(1));
        rq.occupied = ($urandom_range(99) < 55);
        if ($urandom_range(99) < 85) rq.cell_index = 12'($urandom_range(scanned_cells() - 1));
        else rq.cell_index = 12'($urandom);
        return rq;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, o_data);
                fail_count++;
            end else begin
                want = pending_rsp.pop_front();
                if (o_data.occupancy !== want.occupancy) begin
                    $display("%0t: occupancy expected %0d actual %0d", $time,
                             want.occupancy, o_data.occupancy);
                    fail_count++;
                end
                if (o_data.cell_cost !== want.cell_cost) begin
                    $display("%0t: cell_cost expected %0d actual %0d", $time,
                             want.cell_cost, o_data.cell_cost);
                    fail_count++;
                end
                if (o_data.no_obstacle !== want.no_obstacle) begin
                    $display("%0t: no_obstacle expected %0d actual %0d", $time,
                             want.no_obstacle, o_data.no_obstacle);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("grid_obstacle_cost_inflation_tb: FAIL");
            $finish;
        end
    end

    initial begin
        t_dir_row dir_rows [15];
        t_setting settings [7];
        t_setting s;
        t_rsp     none;

        none = '0;
        m_w = 7'd64; m_h = 7'd64; m_ins_dist = 16'd512; m_decay = 16'd256;
        m_occ_th = 16'd42598; m_free_th = 16'd12845;
        m_ins_cost = 8'd253; m_lethal = 8'd254;

        // empty grid, lethal cell, inside inscribed radius, far corner, clear again
        dir_rows[0]  = '{'{REQ_QUERY, 12'd5, 1'b1}, 1, '{7'd0, 8'd0, 1'b1}};
        dir_rows[1]  = '{'{REQ_LOAD, 12'd0, 1'b1}, 0, none};
        dir_rows[2]  = '{'{REQ_QUERY, 12'd0, 1'b0}, 1, '{7'd100, 8'd254, 1'b0}};
        dir_rows[3]  = '{'{REQ_QUERY, 12'd1, 1'b0}, 1, '{7'd100, 8'd253, 1'b0}};
        dir_rows[4]  = '{'{REQ_QUERY, 12'd130, 1'b1}, 0, none};
        dir_rows[5]  = '{'{REQ_QUERY, 12'd3, 1'b0}, 0, none};
        dir_rows[6]  = '{'{REQ_QUERY, 12'd6, 1'b0}, 0, none};
        dir_rows[7]  = '{'{REQ_QUERY, 12'd4095, 1'b0}, 0, none};
        dir_rows[8]  = '{'{REQ_LOAD, 12'd4095, 1'b1}, 0, none};
        dir_rows[9]  = '{'{REQ_QUERY, 12'd4095, 1'b0}, 1, '{7'd100, 8'd254, 1'b0}};
        dir_rows[10] = '{'{REQ_QUERY, 12'd4094, 1'b0}, 1, '{7'd100, 8'd253, 1'b0}};
        dir_rows[11] = '{'{REQ_QUERY, 12'd2080, 1'b0}, 0, none};
        dir_rows[12] = '{'{REQ_LOAD, 12'd0, 1'b0}, 0, none};
        dir_rows[13] = '{'{REQ_LOAD, 12'd4095, 1'b0}, 0, none};
        dir_rows[14] = '{'{REQ_QUERY, 12'd2730, 1'b1}, 1, '{7'd0, 8'd0, 1'b1}};

        settings[0] = '{7'd8, 7'd8, 16'd512, 16'd256, 16'd42598, 16'd12845,
                        8'd253, 8'd254, 25};
        settings[1] = '{7'd0, 7'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 12};
        settings[2] = '{7'd127, 7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        8'd255, 8'd255, 6};
        settings[3] = '{7'd16, 7'd5, 16'd300, 16'd700, 16'd30000, 16'd30000,
                        8'd1, 8'd100, 25};
        settings[4] = '{7'd12, 7'd9, 16'd0, 16'd40, 16'hFFFF, 16'd0,
                        8'd255, 8'd0, 25};
        s.w = 7'($urandom_range(1, 20)); s.h = 7'($urandom_range(1, 20));
        s.ins_dist = 16'($urandom_range(1200)); s.decay = 16'($urandom_range(1500));
        s.free_th = 16'($urandom_range(30000));
        s.occ_th = s.free_th + 16'($urandom_range(35000));
        s.ins_cost = 8'($urandom); s.lethal = 8'($urandom); s.items = 40;
        settings[5] = s;
        settings[6] = '{7'd64, 7'd64, 16'd512, 16'd256, 16'd42598, 16'd12845,
                        8'd253, 8'd254, 6};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) transfer_item(dir_rows[r].req, dir_rows[r].typed,
                                            dir_rows[r].want);

        foreach (settings[p]) begin
            if (p == 3) begin
                send_idle_pct = 74; recv_idle_pct = 32;
            end else if (p == 5) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            i_valid <= 1'b0;
            drain_results();
            // a load may still be in flight with no result to wait for
            repeat (8) @(posedge i_clk);
            apply_setting(settings[p]);
            for (int k = 0; k < settings[p].items; k++) begin
                // hold off until the block has handed back everything
                if (p == 3 && k == 12) begin
                    i_valid <= 1'b0;
                    drain_results();
                end
                transfer_item(random_item(), 0, none);
            end
        end

        i_valid <= 1'b0;
        drain_results();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (fail_count == 0) $display("grid_obstacle_cost_inflation_tb: PASS");
        else $display("grid_obstacle_cost_inflation_tb: FAIL");
        $finish;
    end

endmodule
